[design/tmprof_pkg.sv]
`timescale 1ns / 1ps
// shared widths, codes and saturating arithmetic for the trapezoidal motion profile unit
package tmprof_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 31;
	localparam int POS_W     = 32;
	localparam int PHASE_W   = 2;
	localparam int IDX_W     = 2;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int DIV_W     = VAL_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	typedef logic [VAL_W-1:0]        val_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [PHASE_W-1:0]      phase_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [PROD_W-1:0]       prod_t;
	typedef logic [DIV_W-1:0]        divq_t;
	typedef logic [DIV_CNT_W-1:0]    divcnt_t;

	localparam val_t VAL_MAX = {VAL_W{1'b1}};
	localparam val_t VAL_ONE = val_t'(1) << FRAC_BITS;

	localparam idx_t REG_MAX_VELOCITY     = 2'd0;
	localparam idx_t REG_MAX_ACCELERATION = 2'd1;
	localparam idx_t REG_TARGET_POSITION  = 2'd2;

	localparam phase_t PHASE_ACCEL  = 2'd0;
	localparam phase_t PHASE_CRUISE = 2'd1;
	localparam phase_t PHASE_DECEL  = 2'd2;

	// unsigned product scaled down by the fraction bits, clamped to the positive range
	function automatic val_t mul_scale(input prod_t p);
		prod_t s;
		s = p >> FRAC_BITS;
		if (|s[PROD_W-1:VAL_W])
			return VAL_MAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic val_t add_sat_u(input val_t a, input val_t b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[VAL_W])
			return VAL_MAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic pos_t add_sat_s(input pos_t a, input pos_t b);
		logic [POS_W:0] s;
		s = {a[POS_W-1], a} + {b[POS_W-1], b};
		if (s[POS_W] != s[POS_W-1]) begin
			if (s[POS_W])
				return {1'b1, {(POS_W-1){1'b0}}};
			return {1'b0, {(POS_W-1){1'b1}}};
		end
		return pos_t'(s[POS_W-1:0]);
	endfunction

endpackage

[design/tmprof_in_if.sv]
`timescale 1ns / 1ps
// time step input channel
interface tmprof_in_if;
	logic                valid;
	logic                ready;
	tmprof_pkg::val_t    time_step;

	modport source (output valid, output time_step, input ready);
	modport sink (input valid, input time_step, output ready);
endinterface

[design/tmprof_out_if.sv]
`timescale 1ns / 1ps
// setpoint result channel
interface tmprof_out_if;
	logic                valid;
	logic                ready;
	tmprof_pkg::pos_t    position;
	tmprof_pkg::phase_t  phase;
	logic                done_res;

	modport source (output valid, output position, output phase, output done_res, input ready);
	modport sink (input valid, input position, input phase, input done_res, output ready);
endinterface

[design/tmprof_cfg_if.sv]
`timescale 1ns / 1ps
// configuration register write channel
interface tmprof_cfg_if;
	logic                valid;
	logic                ready;
	tmprof_pkg::idx_t    index;
	tmprof_pkg::val_t    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[design/trapezoidal_motion_profile_unit.sv]
`timescale 1ns / 1ps
// trapezoidal motion profile unit: sequencer around one shared multiplier and a radix-2 divider
// Each accepted time step yields one setpoint (position, phase, sticky done flag) and then
// advances the elapsed time by that step. The block works on one transaction at a time. The
// single 31x31 multiplier is used two to four times per item with a register stage after each
// use; while decelerating the position is worked out twice, for the current and the next time.
// The first item after reset also plans the move, which adds two 47-step restoring divisions
// (one quotient bit per cycle). A finished setpoint sits in an output register, so the next
// time step can be taken while it waits; if that register is still full when the next setpoint
// is ready, the block holds in its last step until the waiting setpoint is taken. Configuration
// writes are always accepted; the plan is kept until reset, while the per-step formulas use the
// current register values.
module trapezoidal_motion_profile_unit (
	input logic                clk,
	input logic                arst_n,
	tmprof_in_if.sink          sample,
	tmprof_out_if.source       setpoint,
	tmprof_cfg_if.sink         cfg
);

	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] S_IDLE   = 5'd0;
	localparam logic [STATE_W-1:0] S_SEL    = 5'd1;
	localparam logic [STATE_W-1:0] S_TN     = 5'd2;
	localparam logic [STATE_W-1:0] S_SQ     = 5'd3;
	localparam logic [STATE_W-1:0] S_SQ_W   = 5'd4;
	localparam logic [STATE_W-1:0] S_AM     = 5'd5;
	localparam logic [STATE_W-1:0] S_AM_W   = 5'd6;
	localparam logic [STATE_W-1:0] S_C_AT   = 5'd7;
	localparam logic [STATE_W-1:0] S_C_AT_W = 5'd8;
	localparam logic [STATE_W-1:0] S_C_E    = 5'd9;
	localparam logic [STATE_W-1:0] S_C_E_W  = 5'd10;
	localparam logic [STATE_W-1:0] S_DONE   = 5'd11;
	localparam logic [STATE_W-1:0] S_DIV    = 5'd12;
	localparam logic [STATE_W-1:0] S_P_AT   = 5'd13;
	localparam logic [STATE_W-1:0] S_P_AT_W = 5'd14;
	localparam logic [STATE_W-1:0] S_P_SQ   = 5'd15;
	localparam logic [STATE_W-1:0] S_P_SQ_W = 5'd16;
	localparam logic [STATE_W-1:0] S_P_AM   = 5'd17;
	localparam logic [STATE_W-1:0] S_P_AM_W = 5'd18;
	localparam logic [STATE_W-1:0] S_P_CD   = 5'd19;
	localparam logic [STATE_W-1:0] S_P_CT   = 5'd20;
	localparam logic [STATE_W-1:0] S_P_CT_W = 5'd21;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] ret_q;

	// configuration
	tmprof_pkg::val_t vmax_q;
	tmprof_pkg::val_t amax_q;
	tmprof_pkg::val_t target_q;

	// profile state
	tmprof_pkg::val_t elapsed_q;
	tmprof_pkg::val_t accel_time_q;
	tmprof_pkg::val_t accel_dist_q;
	tmprof_pkg::val_t cruise_dist_q;
	tmprof_pkg::val_t cruise_time_q;
	logic             plan_ready_q;
	logic             finished_q;

	// working registers
	tmprof_pkg::val_t   step_q;
	tmprof_pkg::val_t   e_next_q;
	tmprof_pkg::val_t   total_q;
	tmprof_pkg::val_t   tn_q;
	tmprof_pkg::pos_t   tmp_q;
	tmprof_pkg::pos_t   pos_q;
	tmprof_pkg::phase_t phase_q;
	logic               ahead_q;

	// shared multiplier
	tmprof_pkg::val_t  mul_a;
	tmprof_pkg::val_t  mul_b;
	tmprof_pkg::prod_t prod_q;
	tmprof_pkg::val_t  mres;
	tmprof_pkg::val_t  half_res;
	tmprof_pkg::pos_t  decel_pos;

	// divider
	tmprof_pkg::divq_t   dq_q;
	tmprof_pkg::val_t    rem_q;
	tmprof_pkg::val_t    den_q;
	tmprof_pkg::divcnt_t cnt_q;
	logic                num_zero_q;
	logic                den_zero_q;
	logic [tmprof_pkg::VAL_W:0] div_sh;
	logic                div_ge;
	tmprof_pkg::val_t    div_res;

	// combinational helpers
	logic [tmprof_pkg::VAL_W+1:0] total_sum;
	tmprof_pkg::val_t  total_c;
	logic [tmprof_pkg::VAL_W:0] cruise_end;
	tmprof_pkg::val_t  tn_src;
	tmprof_pkg::pos_t  tn_diff;
	tmprof_pkg::val_t  tn_abs;
	tmprof_pkg::pos_t  cd_diff;
	tmprof_pkg::val_t  cd_c;

	// output register
	logic               out_valid_q;
	tmprof_pkg::pos_t   out_pos_q;
	tmprof_pkg::phase_t out_phase_q;
	logic               out_done_q;
	logic               out_load;

	assign sample.ready      = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign setpoint.valid    = out_valid_q;
	assign setpoint.position = out_pos_q;
	assign setpoint.phase    = out_phase_q;
	assign setpoint.done_res = out_done_q;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || setpoint.ready);

	always_comb begin
		case (state_q)
			S_P_SQ: begin
				mul_a = accel_time_q;
				mul_b = accel_time_q;
			end
			S_P_AM, S_AM: begin
				mul_a = amax_q;
				mul_b = tmp_q[tmprof_pkg::VAL_W-1:0];
			end
			S_SQ: begin
				mul_a = tn_q;
				mul_b = tn_q;
			end
			S_C_AT: begin
				mul_a = vmax_q;
				mul_b = accel_time_q;
			end
			S_C_E: begin
				mul_a = vmax_q;
				mul_b = elapsed_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mres      = tmprof_pkg::mul_scale(prod_q);
	assign half_res  = mres >> 1;
	assign decel_pos = tmprof_pkg::pos_t'({1'b0, target_q}) - tmprof_pkg::pos_t'({1'b0, half_res});

	assign div_sh  = {rem_q, dq_q[tmprof_pkg::DIV_W-1]};
	assign div_ge  = div_sh >= {1'b0, den_q};
	assign div_res = num_zero_q ? '0 :
		den_zero_q ? tmprof_pkg::VAL_MAX :
		(|dq_q[tmprof_pkg::DIV_W-1:tmprof_pkg::VAL_W]) ? tmprof_pkg::VAL_MAX :
		dq_q[tmprof_pkg::VAL_W-1:0];

	assign total_sum  = {2'b00, accel_time_q} + {2'b00, accel_time_q} + {2'b00, cruise_time_q};
	assign total_c    = (|total_sum[tmprof_pkg::VAL_W+1:tmprof_pkg::VAL_W]) ?
		tmprof_pkg::VAL_MAX : total_sum[tmprof_pkg::VAL_W-1:0];
	assign cruise_end = {1'b0, accel_time_q} + {1'b0, cruise_time_q};

	assign tn_src  = ahead_q ? e_next_q : elapsed_q;
	assign tn_diff = tmprof_pkg::pos_t'({1'b0, tn_src}) - tmprof_pkg::pos_t'({1'b0, total_q});
	assign tn_abs  = tn_diff[tmprof_pkg::POS_W-1] ?
		tmprof_pkg::val_t'(-tn_diff) : tn_diff[tmprof_pkg::VAL_W-1:0];

	assign cd_diff = tmprof_pkg::pos_t'({1'b0, target_q}) - tmprof_pkg::pos_t'({accel_dist_q, 1'b0});
	assign cd_c    = cd_diff[tmprof_pkg::POS_W-1] ? '0 : cd_diff[tmprof_pkg::VAL_W-1:0];

	// control and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			vmax_q        <= tmprof_pkg::VAL_ONE;
			amax_q        <= tmprof_pkg::VAL_ONE;
			target_q      <= '0;
			elapsed_q     <= '0;
			accel_time_q  <= '0;
			accel_dist_q  <= '0;
			cruise_dist_q <= '0;
			cruise_time_q <= '0;
			plan_ready_q  <= 1'b0;
			finished_q    <= 1'b0;
			ahead_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					tmprof_pkg::REG_MAX_VELOCITY:     vmax_q   <= cfg.wdata;
					tmprof_pkg::REG_MAX_ACCELERATION: amax_q   <= cfg.wdata;
					tmprof_pkg::REG_TARGET_POSITION:  target_q <= cfg.wdata;
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (setpoint.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (sample.valid)
						state_q <= plan_ready_q ? S_SEL : S_P_AT;
				end
				S_P_AT: begin
					ret_q   <= S_P_AT_W;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= ret_q;
				end
				S_P_AT_W: begin
					accel_time_q <= div_res;
					state_q      <= S_P_SQ;
				end
				S_P_SQ:   state_q <= S_P_SQ_W;
				S_P_SQ_W: state_q <= S_P_AM;
				S_P_AM:   state_q <= S_P_AM_W;
				S_P_AM_W: begin
					accel_dist_q <= half_res;
					state_q      <= S_P_CD;
				end
				S_P_CD: begin
					cruise_dist_q <= cd_c;
					state_q       <= S_P_CT;
				end
				S_P_CT: begin
					ret_q   <= S_P_CT_W;
					state_q <= S_DIV;
				end
				S_P_CT_W: begin
					cruise_time_q <= div_res;
					plan_ready_q  <= 1'b1;
					state_q       <= S_SEL;
				end
				S_SEL: begin
					ahead_q <= 1'b0;
					if (elapsed_q < accel_time_q)
						state_q <= S_SQ;
					else if ({1'b0, elapsed_q} <= cruise_end)
						state_q <= S_C_AT;
					else
						state_q <= S_TN;
				end
				S_TN:     state_q <= S_SQ;
				S_SQ:     state_q <= S_SQ_W;
				S_SQ_W:   state_q <= S_AM;
				S_AM:     state_q <= S_AM_W;
				S_AM_W: begin
					if (phase_q == tmprof_pkg::PHASE_ACCEL) begin
						state_q <= S_DONE;
					end else if (!ahead_q) begin
						ahead_q <= 1'b1;
						state_q <= S_TN;
					end else begin
						if (decel_pos < pos_q)
							finished_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_C_AT:   state_q <= S_C_AT_W;
				S_C_AT_W: state_q <= S_C_E;
				S_C_E:    state_q <= S_C_E_W;
				S_C_E_W:  state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						elapsed_q <= e_next_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (state_q == S_IDLE && sample.valid)
			step_q <= sample.time_step;

		case (state_q)
			S_P_AT: begin
				dq_q       <= {vmax_q, {tmprof_pkg::FRAC_BITS{1'b0}}};
				rem_q      <= '0;
				den_q      <= amax_q;
				cnt_q      <= tmprof_pkg::divcnt_t'(tmprof_pkg::DIV_W - 1);
				num_zero_q <= (vmax_q == '0);
				den_zero_q <= (amax_q == '0);
			end
			S_P_CT: begin
				dq_q       <= {cruise_dist_q, {tmprof_pkg::FRAC_BITS{1'b0}}};
				rem_q      <= '0;
				den_q      <= vmax_q;
				cnt_q      <= tmprof_pkg::divcnt_t'(tmprof_pkg::DIV_W - 1);
				num_zero_q <= (cruise_dist_q == '0);
				den_zero_q <= (vmax_q == '0);
			end
			S_DIV: begin
				dq_q  <= {dq_q[tmprof_pkg::DIV_W-2:0], div_ge};
				rem_q <= div_ge ? tmprof_pkg::val_t'(div_sh - {1'b0, den_q}) :
					div_sh[tmprof_pkg::VAL_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			S_P_SQ_W, S_SQ_W: tmp_q <= tmprof_pkg::pos_t'({1'b0, mres});
			S_SEL: begin
				e_next_q <= tmprof_pkg::add_sat_u(elapsed_q, step_q);
				total_q  <= total_c;
				tn_q     <= elapsed_q;
				if (elapsed_q < accel_time_q)
					phase_q <= tmprof_pkg::PHASE_ACCEL;
				else if ({1'b0, elapsed_q} <= cruise_end)
					phase_q <= tmprof_pkg::PHASE_CRUISE;
				else
					phase_q <= tmprof_pkg::PHASE_DECEL;
			end
			S_TN: tn_q <= tn_abs;
			S_AM_W: begin
				if (phase_q == tmprof_pkg::PHASE_ACCEL)
					pos_q <= tmprof_pkg::pos_t'({1'b0, half_res});
				else if (!ahead_q)
					pos_q <= decel_pos;
			end
			S_C_AT_W: tmp_q <= tmprof_pkg::pos_t'({1'b0, accel_dist_q})
				- tmprof_pkg::pos_t'({1'b0, mres});
			S_C_E_W: pos_q <= tmprof_pkg::add_sat_s(tmprof_pkg::pos_t'({1'b0, mres}), tmp_q);
			default: ;
		endcase

		if (out_load) begin
			out_pos_q   <= pos_q;
			out_phase_q <= phase_q;
			out_done_q  <= finished_q;
		end
	end

	a_plan_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		plan_ready_q |=> plan_ready_q)
		else $error("plan ready flag dropped");

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("done flag dropped");

	a_plan_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && !plan_ready_q) |=> (state_q == S_P_AT))
		else $error("first transaction skipped planning");

	a_done_planned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> plan_ready_q)
		else $error("result produced without a plan");

	a_done_decel: assert property (@(posedge clk) disable iff (!arst_n)
		(setpoint.valid && setpoint.done_res && !finished_q) |-> 1'b0)
		else $error("done shown before the flag was set");

endmodule
